[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the design files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/sdae_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdae_pkg
// Types and constants shared by the signed decimal ASCII emitter.
// ----------------------------------------------------------------------------
package sdae_pkg;

    localparam int unsigned NUM_W      = 32;
    localparam int unsigned CHAR_W     = 6;
    localparam int unsigned DIGITS     = 10;
    localparam int unsigned BCD_W      = 4 * DIGITS;
    localparam int unsigned BIT_CNT_W  = $clog2(NUM_W);
    localparam int unsigned LEFT_W     = $clog2(DIGITS);

    localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CONV = 5'b00010,
        S_SIGN = 5'b00100,
        S_SKIP = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic emit_sign;
        logic skip;
        logic emit_digit;
    } t_cmd;

    typedef struct packed {
        logic neg;
        logic conv_done;
        logic top_zero;
        logic left_zero;
        logic out_free;
    } t_stat;

endpackage

[design/sdae_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdae_dp
// Datapath: magnitude, shift-and-add-3 conversion, digit walk and output word.
// ----------------------------------------------------------------------------
module sdae_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic signed [31:0]            i_number,
    input  sdae_pkg::t_cmd                i_cmd,
    output sdae_pkg::t_stat               o_stat,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [sdae_pkg::CHAR_W-1:0]   o_char_code,
    output logic                          o_last
);
    import sdae_pkg::*;

    logic [NUM_W-1:0]     r_bin, n_bin;
    logic [BCD_W-1:0]     r_bcd, n_bcd;
    logic [BCD_W-1:0]     w_adj;
    logic [BIT_CNT_W-1:0] r_cnt, n_cnt;
    logic [LEFT_W-1:0]    r_left, n_left;
    logic                 r_neg, n_neg;
    logic                 r_valid, n_valid;
    logic [CHAR_W-1:0]    r_char, n_char;
    logic                 r_last, n_last;
    logic [3:0]           w_top;
    logic [NUM_W-1:0]     w_raw;

    assign w_raw = $unsigned(i_number);
    assign w_top = r_bcd[BCD_W-1 -: 4];

    always_comb begin
        w_adj = r_bcd;
        for (int k = 0; k < DIGITS; k++) begin
            if (w_adj[4*k +: 4] >= 4'd5) begin
                w_adj[4*k +: 4] = w_adj[4*k +: 4] + 4'd3;
            end
        end
    end

    always_comb begin
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        n_cnt   = r_cnt;
        n_left  = r_left;
        n_neg   = r_neg;
        n_valid = r_valid;
        n_char  = r_char;
        n_last  = r_last;
        if (i_out_ready) begin
            n_valid = 1'b0;
        end
        if (i_cmd.load) begin
            n_neg  = w_raw[NUM_W-1];
            n_bin  = w_raw[NUM_W-1] ? (~w_raw + {{(NUM_W-1){1'b0}}, 1'b1}) : w_raw;
            n_bcd  = '0;
            n_cnt  = '0;
            n_left = LEFT_W'(DIGITS - 1);
        end
        if (i_cmd.step) begin
            n_bcd = {w_adj[BCD_W-2:0], r_bin[NUM_W-1]};
            n_bin = {r_bin[NUM_W-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
        end
        if (i_cmd.emit_sign) begin
            n_valid = 1'b1;
            n_char  = CH_MINUS;
            n_last  = 1'b0;
        end
        if (i_cmd.skip) begin
            n_bcd  = {r_bcd[BCD_W-5:0], 4'd0};
            n_left = r_left - 1'b1;
        end
        if (i_cmd.emit_digit) begin
            n_valid = 1'b1;
            n_char  = CH_ZERO + {2'b00, w_top};
            n_last  = (r_left == '0);
            n_bcd   = {r_bcd[BCD_W-5:0], 4'd0};
            n_left  = r_left - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
            r_left  <= '0;
            r_neg   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_cnt   <= n_cnt;
            r_left  <= n_left;
            r_neg   <= n_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_stat.neg       = r_neg;
    assign o_stat.conv_done = &r_cnt;
    assign o_stat.top_zero  = (w_top == 4'd0);
    assign o_stat.left_zero = (r_left == '0);
    assign o_stat.out_free  = !r_valid || i_out_ready;

    assign o_out_valid = r_valid;
    assign o_char_code = r_char;
    assign o_last      = r_last;

endmodule

[design/sdae_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdae_ctrl
// Controller: sequences load, conversion, sign, leading-zero skip and digits.
// ----------------------------------------------------------------------------
module sdae_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  sdae_pkg::t_stat  i_stat,
    output sdae_pkg::t_cmd   o_cmd
);
    import sdae_pkg::*;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.step = 1'b1;
                if (i_stat.conv_done) begin
                    n_state = i_stat.neg ? S_SIGN : S_SKIP;
                end
            end
            S_SIGN: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_sign = 1'b1;
                    n_state         = S_SKIP;
                end
            end
            S_SKIP: begin
                if (i_stat.top_zero && !i_stat.left_zero) begin
                    o_cmd.skip = 1'b1;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_digit = 1'b1;
                    if (i_stat.left_zero) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

[design/signed_decimal_ascii_emitter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_decimal_ascii_emitter
// Prints a signed 32-bit integer as decimal ASCII characters, sign first.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake                 Word
// input    in         i_in_valid / o_in_ready   i_number
// output   out        o_out_valid / i_out_ready o_char_code, o_last
//
// Each word is loaded, converted in 32 shift-and-add-3 steps, given a minus sign
// when negative, stripped of leading zeros in the skip state, and emitted one
// character at a time through the single output register.
// Reset is synchronous; only control registers are cleared.
// A stalled output holds the sequencer; the last character may wait in the
// output register while the next word is accepted.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module signed_decimal_ascii_emitter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [31:0]            i_number,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [sdae_pkg::CHAR_W-1:0]   o_char_code,
    output logic                          o_last
);
    import sdae_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    sdae_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    sdae_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_number    (i_number),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

    `ASSERT_NEXT(a_last_digit_idle, i_clk, i_rst_n, w_cmd.emit_digit && w_stat.left_zero, o_in_ready, "sequencer not idle after last digit")
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "word accepted while busy")
    `ASSERT_NOW(a_sign_only_neg, i_clk, i_rst_n, w_cmd.emit_sign, w_stat.neg, "sign emitted for a non-negative word")
    `ASSERT_NOW(a_idle_quiet, i_clk, i_rst_n, o_in_ready, !w_cmd.step && !w_cmd.skip, "datapath working while idle")

endmodule
